// ----- design/wsfu_pkg.sv -----
// Shared constants and types of the WebSocket frame unmasker.
`default_nettype none
package wsfu_pkg;

    localparam int LEN_BITS    = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] LEN7_MASK  = 7'h7F;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_BYTES  = 3'd4;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// ----- design/wsfu_front.sv -----
// Frame parser: header, length, extended length and key; queues payload bytes.
`default_nettype none
module wsfu_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               frame_valid,
    output logic                    frame_stall,
    input  wire logic [7:0]         in_byte,
    input  wire wsfu_pkg::q_status_t q_status,
    output wsfu_pkg::q_push_t       q_push
);
    import wsfu_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN7,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [2:0]          count_reg, count_next;
    logic [LEN_BITS-1:0] remaining_reg, remaining_next;
    logic [31:0]         key_reg, key_next;
    logic [1:0]          key_idx_reg, key_idx_next;

    logic       accept;
    logic [6:0] len7;
    logic [2:0] count_inc;
    logic [7:0] key_byte;
    logic       is_last;

    assign frame_stall = q_status.full;
    assign accept      = frame_valid && !frame_stall;
    assign len7        = in_byte[6:0] & LEN7_MASK;
    assign count_inc   = count_reg + 3'd1;
    assign is_last     = (remaining_reg == {{(LEN_BITS-1){1'b0}}, 1'b1});

    always_comb
    begin
        case (key_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        remaining_next = remaining_reg;
        key_next       = key_reg;
        key_idx_next   = key_idx_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                phase_next = PH_LEN7;
            end
            PH_LEN7:
            begin
                remaining_next = '0;
                key_idx_next   = 2'd0;
                key_next       = '0;
                if (len7 == LEN7_EXT16)
                begin
                    count_next = EXT16_LAST;
                    phase_next = PH_EXTLEN;
                end
                else if (len7 == LEN7_EXT64)
                begin
                    count_next = EXT64_LAST;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    remaining_next = {{(LEN_BITS-7){1'b0}}, len7};
                    count_next     = 3'd0;
                    phase_next     = PH_KEY;
                end
            end
            PH_EXTLEN:
            begin
                remaining_next = {remaining_reg[LEN_BITS-9:0], in_byte};
                if (count_reg == 3'd0)
                    phase_next = PH_KEY;
                else
                    count_next = count_reg - 3'd1;
            end
            PH_KEY:
            begin
                key_next   = {key_reg[23:0], in_byte};
                count_next = count_inc;
                if (count_inc >= KEY_BYTES)
                begin
                    count_next   = 3'd0;
                    key_idx_next = 2'd0;
                    phase_next   = (remaining_reg == '0) ? PH_HEADER : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                remaining_next = remaining_reg - {{(LEN_BITS-1){1'b0}}, 1'b1};
                key_idx_next   = key_idx_reg + 2'd1;
                if (is_last)
                    phase_next = PH_HEADER;
            end
            default:
            begin
                phase_next = PH_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            count_reg     <= 3'd0;
            remaining_reg <= '0;
            key_reg       <= '0;
            key_idx_reg   <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            remaining_reg <= remaining_next;
            key_reg       <= key_next;
            key_idx_reg   <= key_idx_next;
        end
    end

    assign q_push.push       = accept && (phase_reg == PH_PAYLOAD);
    assign q_push.entry.data = in_byte;
    assign q_push.entry.key  = key_byte;
    assign q_push.entry.last = is_last;

    a_last_returns_header: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push.push && q_push.entry.last) |=> (phase_reg == PH_HEADER))
        else $error("last payload byte did not return parser to header");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (remaining_reg != '0))
        else $error("payload phase with zero remaining length");

endmodule
`default_nettype wire

// ----- design/wsfu_queue.sv -----
// Short FIFO between the parser and the output stage.
`default_nettype none
module wsfu_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wsfu_pkg::q_push_t   q_push,
    input  wire logic                pop,
    output wsfu_pkg::q_status_t      q_status,
    output wsfu_pkg::entry_t         head
);
    import wsfu_pkg::*;

    entry_t               store_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 do_push;
    logic                 do_pop;

    assign q_status.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = q_push.push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= q_push.entry;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_lost: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push |-> !q_status.full)
        else $error("push into full queue");

endmodule
`default_nettype wire

// ----- design/wsfu_back.sv -----
// Output stage: unmask the queue head into the result register.
`default_nettype none
module wsfu_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wsfu_pkg::q_status_t q_status,
    input  wire wsfu_pkg::entry_t    head,
    output logic                     pop,
    output logic                     payload_valid,
    input  wire logic                payload_stall,
    output logic [7:0]               payload_byte,
    output logic                     last_byte
);
    import wsfu_pkg::*;

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign pop = !q_status.empty && (!valid_reg || !payload_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !payload_stall)
            valid_reg <= !q_status.empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= head.data ^ head.key;
            last_reg <= head.last;
        end
    end

    assign payload_valid = valid_reg;
    assign payload_byte  = data_reg;
    assign last_byte     = last_reg;

endmodule
`default_nettype wire

// ----- design/websocket_frame_unmasker_top.sv -----
// Top level of the WebSocket frame unmasker.
//
//  channel   valid          stall          fields
//  frame     frame_valid    frame_stall    in_byte
//  payload   payload_valid  payload_stall  payload_byte, last_byte
//
// One frame byte is taken per cycle while frame_stall is low.
// A four-entry queue between parser and output register absorbs output stalls.
// frame_stall is high only while that queue is full.
// Reset puts the parser in wait for the first header byte and empties the queue.
`default_nettype none
module websocket_frame_unmasker_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       frame_valid,
    output logic            frame_stall,
    input  wire logic [7:0] in_byte,
    output logic            payload_valid,
    input  wire logic       payload_stall,
    output logic [7:0]      payload_byte,
    output logic            last_byte
);
    import wsfu_pkg::*;

    q_push_t   q_push;
    q_status_t q_status;
    entry_t    head;
    logic      pop;

    wsfu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .in_byte     (in_byte),
        .q_status    (q_status),
        .q_push      (q_push)
    );

    wsfu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    wsfu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head          (head),
        .pop           (pop),
        .payload_valid (payload_valid),
        .payload_stall (payload_stall),
        .payload_byte  (payload_byte),
        .last_byte     (last_byte)
    );

endmodule
`default_nettype wire

// ----- dv/tb_websocket_frame_unmasker_top.sv -----
// Self-checking testbench for the WebSocket frame unmasker with a byte-level payload scoreboard.
`timescale 1ns / 100ps
module tb_websocket_frame_unmasker_top;
    import wsfu_pkg::*;

    localparam int FRAME_BYTES = 1500;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_WAIT    = 16;
    localparam int DRAIN_WAIT  = 40;

    typedef enum logic [2:0] {
        WAIT_HEADER,
        READ_LEN7,
        READ_EXTLEN,
        READ_KEY,
        PAYLOAD
    } parse_phase_t;

    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    class payload_scoreboard;
        typedef struct packed {
            logic [7:0] data;
            logic       last;
        } payload_t;

        parse_phase_t        phase      = WAIT_HEADER;
        logic [2:0]          field_cnt  = '0;
        logic [LEN_BITS-1:0] bytes_left = '0;
        logic [31:0]         mask_key   = '0;
        logic [1:0]          key_pos    = '0;
        payload_t            expected_q[$];
        int                  mismatches = 0;

        function void note_byte(logic [7:0] b);
            logic [6:0] len7;
            payload_t   p;
            len7 = b[6:0] & LEN7_MASK;
            case (phase)
                WAIT_HEADER: phase = READ_LEN7;
                READ_LEN7:
                begin
                    bytes_left = '0;
                    key_pos    = '0;
                    mask_key   = '0;
                    if (len7 == LEN7_EXT16)
                    begin
                        field_cnt = EXT16_LAST;
                        phase     = READ_EXTLEN;
                    end
                    else if (len7 == LEN7_EXT64)
                    begin
                        field_cnt = EXT64_LAST;
                        phase     = READ_EXTLEN;
                    end
                    else
                    begin
                        bytes_left = LEN_BITS'(len7);
                        field_cnt  = '0;
                        phase      = READ_KEY;
                    end
                end
                READ_EXTLEN:
                begin
                    bytes_left = {bytes_left[LEN_BITS-9:0], b};
                    if (field_cnt == 3'd0)
                        phase = READ_KEY;
                    else
                        field_cnt = field_cnt - 3'd1;
                end
                READ_KEY:
                begin
                    mask_key  = {mask_key[23:0], b};
                    field_cnt = field_cnt + 3'd1;
                    if (field_cnt >= KEY_BYTES)
                    begin
                        field_cnt = '0;
                        key_pos   = '0;
                        phase     = (bytes_left == '0) ? WAIT_HEADER : PAYLOAD;
                    end
                end
                PAYLOAD:
                begin
                    p.data     = b ^ mask_key[(3 - int'(key_pos)) * 8 +: 8];
                    bytes_left = bytes_left - 1'b1;
                    key_pos    = key_pos + 2'd1;
                    p.last     = (bytes_left == '0);
                    if (p.last)
                        phase = WAIT_HEADER;
                    expected_q.push_back(p);
                end
                default: phase = WAIT_HEADER;
            endcase
        endfunction

        function void check_payload(logic [7:0] data, logic last);
            payload_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected payload: byte %02h last %0b", data, last);
                return;
            end
            want = expected_q.pop_front();
            if (want.data !== data || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("payload mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                             want.data, want.last, data, last);
            end
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       frame_valid   = 1'b0;
    logic [7:0] in_byte       = 8'h00;
    logic       payload_stall = 1'b0;
    logic       frame_stall;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       last_byte;

    payload_scoreboard sb = new;
    int  cycle_count = 0;
    int  bytes_sent  = 0;
    bit  tx_burst    = 1'b0;
    bit  rx_burst    = 1'b0;

    logic [7:0] directed_bytes[23] = '{
        8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A,
        8'h00, 8'h81, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF,
        8'h88, 8'hFE, 8'h00, 8'h02, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h00, 8'hFF
    };

    websocket_frame_unmasker_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (frame_valid),
        .frame_stall   (frame_stall),
        .in_byte       (in_byte),
        .payload_valid (payload_valid),
        .payload_stall (payload_stall),
        .payload_byte  (payload_byte),
        .last_byte     (last_byte)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
                sb.note_byte(in_byte);
            if (payload_valid && !payload_stall)
                sb.check_payload(payload_byte, last_byte);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 63) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        in_byte     <= b;
        do
            @(posedge clk);
        while (!(frame_valid && !frame_stall));
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [63:0] plen, input len_form_t form,
                              input int unsigned body);
        logic [31:0] key;
        key = $urandom;
        send_byte(8'($urandom));
        case (form)
            LEN_SHORT: send_byte({1'($urandom), plen[6:0]});
            LEN_EXT16:
            begin
                send_byte({1'($urandom), LEN7_EXT16});
                send_byte(plen[15:8]);
                send_byte(plen[7:0]);
            end
            default:
            begin
                send_byte({1'($urandom), LEN7_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(plen[8*i +: 8]);
            end
        endcase
        for (int i = 3; i >= 0; i--)
            send_byte(key[8*i +: 8]);
        repeat (body) send_byte(8'($urandom));
    endtask

    initial
    begin
        int n;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            n = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (n > 0)
            begin
                payload_stall <= 1'b1;
                repeat (n) @(posedge clk);
                payload_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(payload_valid && !payload_stall));
        end
    end

    initial
    begin
        int          pick;
        logic [63:0] plen;
        len_form_t   form;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        while (bytes_sent < FRAME_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                form = LEN_SHORT;
                plen = 64'd125;
            end
            else if (pick < 65)
            begin
                form = LEN_SHORT;
                plen = 64'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 124)
                                                       : $urandom_range(0, 12));
            end
            else if (pick < 85)
            begin
                form = LEN_EXT16;
                plen = 64'(($urandom_range(0, 7) == 0) ? $urandom_range(126, 300)
                                                       : $urandom_range(0, 40));
            end
            else
            begin
                form = LEN_EXT64;
                plen = 64'($urandom_range(0, 40));
            end
            send_frame(plen, form, 32'(plen));
        end

        // leave a frame with an all-ones 64-bit length open at the end
        send_frame({64{1'b1}}, LEN_EXT64, 20);
        frame_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
